// ----- src/slp_pkg.sv -----
package slp_pkg;

  // Result value width; the hex token saturates at 2**VALUE_BITS - 1.
  localparam int unsigned VALUE_BITS = 16;

  // Entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_F    = 8'h46;

  localparam logic [7:0] ID_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_POS     = 2'd0,
    KIND_SENSOR  = 2'd1,
    KIND_EVENT   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } slp_kind_e;

  // One classified byte, as the front hands it to the back.
  typedef struct packed {
    logic      is_nl;
    logic      is_sp;
    logic      is_dec;
    logic      is_hex;
    logic [3:0] digit;
    slp_kind_e kind;
  } slp_item_t;

endpackage

// ----- src/slp_byte_if.sv -----
interface slp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/slp_result_if.sv -----
interface slp_result_if;
  logic                             valid;
  logic                             ready;
  slp_pkg::slp_kind_e               msg_kind;
  logic [7:0]                       unit_id;
  logic [slp_pkg::VALUE_BITS-1:0]   data_value;
  logic                             motor_error;

  modport source (
    output valid, output msg_kind, output unit_id, output data_value, output motor_error,
    input ready
  );
  modport sink (
    input valid, input msg_kind, input unit_id, input data_value, input motor_error,
    output ready
  );
endinterface

// ----- src/slp_front.sv -----
module slp_front (
  slp_byte_if.sink            rx_i,
  input  logic                q_full_i,
  output logic                push_o,
  output slp_pkg::slp_item_t  item_o
);
  import slp_pkg::*;

  logic [7:0] b;

  assign b          = rx_i.rx_byte;
  assign rx_i.ready = ~q_full_i;
  assign push_o     = rx_i.valid & ~q_full_i;

  always_comb begin
    item_o        = '0;
    item_o.is_nl  = (b == CH_NEWLINE);
    item_o.is_sp  = (b == CH_SPACE);
    item_o.kind   = KIND_UNKNOWN;
    item_o.digit  = 4'd0;

    if (b inside {[CH_ZERO:CH_NINE]}) begin
      item_o.is_dec = 1'b1;
      item_o.is_hex = 1'b1;
      item_o.digit  = 4'(b - CH_ZERO);
    end else if (b inside {[CH_LC_A:CH_LC_F]}) begin
      item_o.is_hex = 1'b1;
      item_o.digit  = 4'(b - CH_LC_A + 8'd10);
    end else if (b inside {[CH_A:CH_UC_F]}) begin
      item_o.is_hex = 1'b1;
      item_o.digit  = 4'(b - CH_A + 8'd10);
    end

    // message type, only used when this is the first char of the first token
    if (b == CH_A) begin
      item_o.kind = KIND_POS;
    end else if (b inside {CH_S, CH_P}) begin
      item_o.kind = KIND_SENSOR;
    end else if (b == CH_E) begin
      item_o.kind = KIND_EVENT;
    end
  end

endmodule

// ----- src/slp_queue.sv -----
module slp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slp_pkg::slp_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output slp_pkg::slp_item_t item_o,
  input  logic               pop_i
);
  import slp_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  slp_item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/slp_back.sv -----
module slp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  slp_pkg::slp_item_t item_i,
  output logic               pop_o,
  slp_result_if.source       res_o
);
  import slp_pkg::*;

  localparam logic [1:0] TOK_TYPE  = 2'd0;
  localparam logic [1:0] TOK_ID    = 2'd1;
  localparam logic [1:0] TOK_VALUE = 2'd2;
  localparam logic [1:0] TOK_REST  = 2'd3;

  logic [1:0]            tok_idx_q, tok_idx_d;
  logic                  in_tok_q, in_tok_d;
  logic                  stopped_q, stopped_d;
  slp_kind_e             kind_q, kind_d;
  logic [7:0]            id_q, id_d;
  logic [VALUE_BITS-1:0] val_q, val_d;

  logic                  res_valid_q, res_valid_d;
  slp_kind_e             res_kind_q;
  logic [7:0]            res_id_q;
  logic [VALUE_BITS-1:0] res_val_q;
  logic                  res_motor_q;

  logic                  slot_free, load_res, stop_eff;
  logic [11:0]           id_next;
  logic [VALUE_BITS-1:0] val_next;

  // newline needs the output slot; spaces and chars never wait
  assign slot_free = ~res_valid_q | res_o.ready;
  assign pop_o     = q_valid_i & (~item_i.is_nl | slot_free);
  assign load_res  = pop_o & item_i.is_nl;
  assign stop_eff  = in_tok_q & stopped_q;

  assign id_next = {id_q, 3'b000} + {3'b000, id_q, 1'b0} + {8'd0, item_i.digit};
  assign val_next = (|val_q[VALUE_BITS-1 -: 4]) ? '1 : {val_q[VALUE_BITS-5:0], item_i.digit};

  always_comb begin
    tok_idx_d = tok_idx_q;
    in_tok_d  = in_tok_q;
    stopped_d = stopped_q;
    kind_d    = kind_q;
    id_d      = id_q;
    val_d     = val_q;

    if (pop_o) begin
      if (item_i.is_nl) begin
        tok_idx_d = TOK_TYPE;
        in_tok_d  = 1'b0;
        stopped_d = 1'b0;
        kind_d    = KIND_UNKNOWN;
        id_d      = '0;
        val_d     = '0;
      end else if (item_i.is_sp) begin
        if (in_tok_q) begin
          in_tok_d = 1'b0;
          if (tok_idx_q != TOK_REST) begin
            tok_idx_d = tok_idx_q + 1'b1;
          end
        end
      end else begin
        in_tok_d  = 1'b1;
        stopped_d = stop_eff;
        case (tok_idx_q)
          TOK_TYPE: begin
            if (!in_tok_q) begin
              kind_d = item_i.kind;
            end
          end
          TOK_ID: begin
            if (!stop_eff) begin
              if (item_i.is_dec) begin
                id_d = (|id_next[11:8]) ? ID_MAX : id_next[7:0];
              end else begin
                stopped_d = 1'b1;
              end
            end
          end
          TOK_VALUE: begin
            if (!stop_eff) begin
              if (item_i.is_hex) begin
                val_d = val_next;
              end else begin
                stopped_d = 1'b1;
              end
            end
          end
          default: begin
            // tokens past the third are ignored
          end
        endcase
      end
    end
  end

  always_comb begin
    if (load_res) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q   <= TOK_TYPE;
      in_tok_q    <= 1'b0;
      stopped_q   <= 1'b0;
      kind_q      <= KIND_UNKNOWN;
      id_q        <= '0;
      val_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tok_idx_q   <= tok_idx_d;
      in_tok_q    <= in_tok_d;
      stopped_q   <= stopped_d;
      kind_q      <= kind_d;
      id_q        <= id_d;
      val_q       <= val_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_kind_q  <= kind_q;
      res_id_q    <= id_q;
      res_val_q   <= val_q;
      res_motor_q <= (kind_q == KIND_POS) && (val_q == VALUE_BITS'(1));
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.msg_kind    = res_kind_q;
  assign res_o.unit_id     = res_id_q;
  assign res_o.data_value  = res_val_q;
  assign res_o.motor_error = res_motor_q;

endmodule

// ----- src/status_line_parser.sv -----
// Status line parser.
// rx_i takes one ASCII byte per item (valid/ready). Space separates tokens,
// runs of spaces count once, newline ends the line. Token one gives the
// message type by its first char, token two a decimal id (saturates at 255),
// token three a hex value in either case (saturates at all ones).
// res_o carries one item per newline: msg_kind, unit_id, data_value and
// motor_error (position message with value 1).
// Throughput: one byte per cycle while the queue is not full. A newline
// is written into the queue, then popped from it and loaded into the output
// register that drives res_o; a byte still queued ahead of it (at most one,
// intake stops at two) is popped first.
// When the receiver stalls, the result holds in its output register while
// spaces and token chars keep draining; the next newline waits in the queue,
// and rx_i.ready drops once the queue is full.
// Reset clears the queue, the line state and the output valid; the first
// byte can be taken as soon as reset is released.
module status_line_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  slp_byte_if.sink      rx_i,
  slp_result_if.source  res_o
);
  import slp_pkg::*;

  logic      push, q_full, q_valid, pop;
  slp_item_t front_item, back_item;

  // classify incoming bytes
  slp_front u_front (
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item)
  );

  // decouples byte intake from result stalls
  slp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (back_item),
    .pop_i   (pop)
  );

  // token tracking, accumulators and result register
  slp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (back_item),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

// ----- src/slp_checker.sv -----
module slp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rx_ready_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input slp_pkg::slp_kind_e           msg_kind_i,
  input logic [7:0]                   unit_id_i,
  input logic [slp_pkg::VALUE_BITS-1:0] data_value_i,
  input logic                         motor_error_i
);
  import slp_pkg::*;

  // stalled result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(msg_kind_i) && $stable(unit_id_i) &&
      $stable(data_value_i) && $stable(motor_error_i))
    else $error("result payload changed while stalled");

  // with the receiver ready, the queue drains and intake never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(res_ready_i) |-> rx_ready_i)
    else $error("byte intake stalled with receiver ready");

  // motor error only on a position message carrying value one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && motor_error_i |->
      (msg_kind_i == KIND_POS) && (data_value_i == VALUE_BITS'(1)))
    else $error("motor error flag inconsistent");

endmodule

bind status_line_parser slp_checker u_slp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_ready_i    (rx_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .msg_kind_i    (res_o.msg_kind),
  .unit_id_i     (res_o.unit_id),
  .data_value_i  (res_o.data_value),
  .motor_error_i (res_o.motor_error)
);

// ----- dv/slp_result_check.sv -----
`timescale 1ns / 1ps

// Watches both channels of the status line parser, predicts one status
// result per newline and compares every accepted result with the oldest
// pending one.
module slp_result_check
  import slp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  slp_byte_if         rx_mon,
  slp_result_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    slp_kind_e             kind;
    logic [7:0]            unit_id;
    logic [VALUE_BITS-1:0] value;
    logic                  motor_err;
  } status_rec_t;

  status_rec_t line_results_q[$];

  // Line state of the predictor
  logic [1:0]            tok_idx;
  logic                  in_tok;
  logic                  conv_stop;
  logic [7:0]            type_ch;
  logic [7:0]            id_acc;
  logic [VALUE_BITS-1:0] val_acc;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t result check: %s", $time, msg);
    fail_count_o++;
  endtask

  // 0..15 for a hex digit in either case, 16 for anything else
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_F) return 5'(c - CH_LC_A + 8'd10);
    if (c >= CH_A && c <= CH_UC_F) return 5'(c - CH_A + 8'd10);
    return 5'd16;
  endfunction

  task automatic clear_line();
    tok_idx   = '0;
    in_tok    = 1'b0;
    conv_stop = 1'b0;
    type_ch   = '0;
    id_acc    = '0;
    val_acc   = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] c);
    status_rec_t           rec;
    int unsigned           next_id;
    logic [VALUE_BITS+4:0] next_val;
    logic [4:0]            nib;
    if (c == CH_NEWLINE) begin
      case (type_ch)
        CH_A:       rec.kind = KIND_POS;
        CH_S, CH_P: rec.kind = KIND_SENSOR;
        CH_E:       rec.kind = KIND_EVENT;
        default:    rec.kind = KIND_UNKNOWN;
      endcase
      rec.unit_id   = id_acc;
      rec.value     = val_acc;
      rec.motor_err = (rec.kind == KIND_POS) && (val_acc == 1);
      line_results_q.push_back(rec);
      clear_line();
    end else if (c == CH_SPACE) begin
      if (in_tok) begin
        in_tok = 1'b0;
        if (tok_idx != 2'd3) tok_idx++;
      end
    end else begin
      if (!in_tok) conv_stop = 1'b0;
      if (tok_idx == 2'd0) begin
        if (!in_tok) type_ch = c;
      end else if (!conv_stop && tok_idx == 2'd1) begin
        if (c < CH_ZERO || c > CH_NINE) begin
          conv_stop = 1'b1;
        end else begin
          next_id = id_acc * 10 + (c - CH_ZERO);
          id_acc  = (next_id > ID_MAX) ? ID_MAX : next_id[7:0];
        end
      end else if (!conv_stop && tok_idx == 2'd2) begin
        nib = hex_nibble(c);
        if (nib > 5'd15) begin
          conv_stop = 1'b1;
        end else begin
          next_val = {val_acc, 4'h0} + nib;
          if (next_val > {VALUE_BITS{1'b1}}) val_acc = '1;
          else val_acc = next_val[VALUE_BITS-1:0];
        end
      end
      in_tok = 1'b1;
    end
  endtask

  task automatic check_result();
    status_rec_t want;
    if (line_results_q.size() == 0) begin
      report_error($sformatf("result with no line pending: kind %0d id %0d value 0x%0h",
                             res_mon.msg_kind, res_mon.unit_id, res_mon.data_value));
      return;
    end
    want = line_results_q.pop_front();
    if (res_mon.msg_kind !== want.kind)
      report_error($sformatf("msg_kind %0d, predicted %0d", res_mon.msg_kind, want.kind));
    if (res_mon.unit_id !== want.unit_id)
      report_error($sformatf("unit_id %0d, predicted %0d", res_mon.unit_id, want.unit_id));
    if (res_mon.data_value !== want.value)
      report_error($sformatf("data_value 0x%0h, predicted 0x%0h",
                             res_mon.data_value, want.value));
    if (res_mon.motor_error !== want.motor_err)
      report_error($sformatf("motor_error %0b, predicted %0b",
                             res_mon.motor_error, want.motor_err));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      line_results_q.delete();
      pending_o = 0;
    end else begin
      if (rx_mon.valid && rx_mon.ready) parse_rx_byte(rx_mon.rx_byte);
      if (res_mon.valid && res_mon.ready) check_result();
      pending_o = line_results_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the status line parser bench: clock, reset, byte stimulus and the
// result side's ready. Prediction and comparison live in slp_result_check.
module tb_top;
  import slp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned IDLE_PCT     = 38;
  localparam logic [7:0]  CH_CR        = 8'h0D;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  slp_byte_if   rx_if ();
  slp_result_if res_if ();

  status_line_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  int unsigned fail_count;
  int unsigned pending_count;

  slp_result_check u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_mon       (rx_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // While set, neither side idles: a long back-to-back stretch.
  bit          no_gaps;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned motor_errors_seen;

  // Result side: random stalls, driven on the falling edge.
  always @(negedge clk_i) begin
    res_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      results_seen++;
      if (res_if.motor_error) motor_errors_seen++;
    end
  end

  // One byte over rx_if. Random idle cycles go in front of it; valid is
  // raised at a falling edge and held until the item is taken at a rising
  // edge. The next call (or the caller) decides valid for the next cycle,
  // so valid gets one assignment per falling edge.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_spaces(input int unsigned n);
    repeat (n) send_byte(CH_SPACE);
  endtask

  // Sender stops and waits until every predicted result has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  // Any byte that is part of a token (not newline, not space).
  function automatic logic [7:0] any_token_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_NEWLINE || b == CH_SPACE);
    return b;
  endfunction

  // Hex digit char, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + v;
    return (($urandom_range(1) != 0) ? CH_LC_A : CH_A) + v - 8'd10;
  endfunction

  // One random line. Mostly well formed: type token, decimal id, hex
  // value, with random separator runs, truncated lines, extra tokens and
  // junk that stops a conversion. The rest is raw noise, newlines and all.
  task automatic send_random_line();
    int unsigned r;
    int unsigned n_tok;
    logic [7:0]  type_b;
    type_b = '0;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
      send_byte(CH_NEWLINE);
      return;
    end
    r = $urandom_range(99);
    if (r < 4) n_tok = 0;
    else if (r < 10) n_tok = 1;
    else if (r < 20) n_tok = 2;
    else if (r < 85) n_tok = 3;
    else n_tok = $urandom_range(4, 5);

    send_spaces($urandom_range(2));
    for (int k = 0; k < n_tok; k++) begin
      if (k > 0) send_spaces($urandom_range(1, 3));
      case (k)
        0: begin
          case ($urandom_range(5))
            0, 5:    type_b = CH_A;
            1:       type_b = CH_S;
            2:       type_b = CH_P;
            3:       type_b = CH_E;
            default: type_b = any_token_char();
          endcase
          send_byte(type_b);
          // trailing chars of the type token are ignored
          repeat ($urandom_range(2)) send_byte(any_token_char());
        end
        1: begin
          // four digits saturate most of the time
          repeat ($urandom_range(1, 4)) send_byte(CH_ZERO + 8'($urandom_range(9)));
          if ($urandom_range(9) == 0) begin
            send_byte(any_token_char());
            send_byte(CH_ZERO + 8'($urandom_range(9)));
          end
        end
        2: begin
          if (type_b == CH_A && $urandom_range(2) == 0) begin
            // value one, maybe with leading zeros: motor error
            repeat ($urandom_range(2)) send_byte(CH_ZERO);
            send_byte(CH_ZERO + 8'd1);
          end else begin
            repeat ($urandom_range(1, 6)) send_byte(hex_char(4'($urandom_range(15))));
          end
          if ($urandom_range(9) == 0) begin
            send_byte(any_token_char());
            send_byte(hex_char(4'($urandom_range(15))));
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_byte(any_token_char());
        end
      endcase
    end
    if ($urandom_range(4) == 0) send_spaces($urandom_range(1, 2));
    if ($urandom_range(7) == 0) send_byte(CH_CR);
    send_byte(CH_NEWLINE);
  endtask

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: %0d results still pending", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned start_cnt;
    bit          paused;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    no_gaps       = 1'b0;
    paused        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines.
    // empty line
    send_text("\n");
    // leading spaces, a run of separators, position reached with value one
    send_text("  A  9 1\n");
    // id and value both saturate, mixed-case hex, fourth token ignored
    send_text("E 999 fFfFf x\n");
    // carriage return ends id conversion, 'g' ends value conversion
    send_text("P 1");
    send_byte(CH_CR);
    send_text("2 7g\n");
    // type from a high byte, NUL inside the type token, 'S' as an id token
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text(" S 12\n");
    hold_until_drained();

    // Random lines, with one back-to-back stretch and one full drain.
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < RANDOM_BYTES) begin
      no_gaps = (bytes_sent - start_cnt >= 300) && (bytes_sent - start_cnt < 450);
      send_random_line();
      if (!paused && bytes_sent - start_cnt >= 550) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    no_gaps = 1'b0;

    hold_until_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes, %0d status results checked (%0d with motor error)",
             bytes_sent, results_seen, motor_errors_seen);
    $display("lines mixed empty, truncated, saturating, junk-stopped and noise input");
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
